/* rtl/fbfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W         = 32;
  localparam int STRIDE_W       = 16;
  localparam int COUNT_W        = 11;
  localparam int PROD_W         = COUNT_W + STRIDE_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int OP_W           = 2;
  localparam int DIV_CNT_W      = $clog2(COUNT_W);
  localparam int DEF_MAX_BLOCKS = 1024;

  // Largest value of an 11-bit counter.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd2;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_CHECK   = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_CHK_PREP,
    S_CHK_TEST,
    S_DIV,
    S_REBUILD,
    S_RESP
  } state_t;

  // Live configuration registers.
  typedef struct packed {
    logic [COUNT_W-1:0]  num_blocks;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   base_address;
  } cfg_t;

  // One result; block_address sits in the lowest bits.
  typedef struct packed {
    logic               is_full;
    logic               is_empty;
    logic [COUNT_W-1:0] available_count;
    logic [COUNT_W-1:0] used_count;
    logic               ok;
    logic [ADDR_W-1:0]  block_address;
  } res_t;

  localparam int OUT_BITS    = $bits(res_t);
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Status of the index divider.
  typedef struct packed {
    logic               done;
    logic               exact;
    logic [COUNT_W-1:0] quotient;
  } div_res_t;

endpackage

/* rtl/fixed_block_free_list_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Fixed-size block pool allocator with a LIFO free list kept in a link memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   request stream: in_tuser is the operation (alloc, free, rebuild,
//          check), in_tdata the block address for free and check.
//   out_*  result stream, one result per request: address, ok, used and
//          available counts, empty and full flags.
//   cfg_*  register writes (base address, stride, block count), always ready;
//          write only while no request is in flight.
// Sequence (request accept to out_tvalid):
//   alloc reads one link memory entry, then answers; with the list empty it
//   skips the read. Free and check divide the offset by the stride in an
//   iterative divider, one of eleven quotient bits per cycle; an address that
//   fails the range test answers without the division. Rebuild sweeps the
//   link memory one entry a cycle over N entries, N being the block count
//   capped at the pool size; with N zero it skips the sweep.
//   A new request is taken only after the result has entered the output
//   register, so no request is accepted before the last one's result is out.
// Reset empties the list and clears the counters; the link memory needs no
// clearing. If the receiver stalls, the result holds in the output register
// while the next request is accepted and processed.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Requests.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fbfl_pkg::ADDR_W-1:0]         in_tdata,   // [31:0] address
  input  logic [fbfl_pkg::OP_W-1:0]           in_tuser,   // [1:0] operation
  // Results.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] block_address, [32] ok, [43:33] used_count,
  // [54:44] available_count, [55] is_empty, [56] is_full, [63:57] zero
  output logic [fbfl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  fbfl_pkg::cfg_t  cfg_r;
  fbfl_pkg::res_t  res;
  fbfl_pkg::res_t  out_res_r;
  logic            out_valid_r;
  logic            res_valid;
  logic            res_take;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= '0;
      cfg_r.stride       <= fbfl_pkg::STRIDE_W'(4);
      cfg_r.num_blocks   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbfl_pkg::CFG_BASE:   cfg_r.base_address <= cfg_data[fbfl_pkg::ADDR_W-1:0];
        fbfl_pkg::CFG_STRIDE: cfg_r.stride       <= cfg_data[fbfl_pkg::STRIDE_W-1:0];
        fbfl_pkg::CFG_BLOCKS: cfg_r.num_blocks   <= cfg_data[fbfl_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fbfl_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (fbfl_pkg::op_t'(in_tuser)),
    .in_addr   (in_tdata),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: loads when empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = fbfl_pkg::OUT_TDATA_W'(out_res_r);

endmodule

/* rtl/fbfl_link_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_link_ram
// Simple dual-port memory holding the next link of every block.
// ----------------------------------------------------------------------------
module fbfl_link_ram #(
  parameter int DEPTH     = fbfl_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/fbfl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_div
// Restoring divider that turns a byte offset into a block index, one
// quotient bit per cycle. The offset is known to be below 2048 strides.
// ----------------------------------------------------------------------------
module fbfl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fbfl_pkg::PROD_W-1:0]    dividend,
  input  logic [fbfl_pkg::STRIDE_W-1:0]  divisor,
  output fbfl_pkg::div_res_t             res
);

  logic                              busy_r;
  logic                              done_r;
  logic [fbfl_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [fbfl_pkg::PROD_W-1:0]       rem_r;
  logic [fbfl_pkg::PROD_W-1:0]       dvs_r;
  logic [fbfl_pkg::COUNT_W-1:0]      q_r;

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= fbfl_pkg::DIV_CNT_W'(fbfl_pkg::COUNT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // One trial subtraction per cycle, divisor shifted down each step.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= fbfl_pkg::PROD_W'(divisor) << (fbfl_pkg::COUNT_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        q_r   <= {q_r[fbfl_pkg::COUNT_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[fbfl_pkg::COUNT_W-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
  end

  assign res.done     = done_r;
  assign res.exact    = (rem_r == '0);
  assign res.quotient = q_r;

endmodule

/* rtl/fbfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Request sequencer: owns the list head and counters, reads and writes the
// link memory, and drives the index divider for free and check.
// ----------------------------------------------------------------------------
module fbfl_ctrl #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fbfl_pkg::op_t                in_op,
  input  logic [fbfl_pkg::ADDR_W-1:0]  in_addr,
  input  fbfl_pkg::cfg_t               cfg,
  output logic                         res_valid,
  input  logic                         res_take,
  output fbfl_pkg::res_t               res
);

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
  localparam int CAP = (MAX_BLOCKS > int'(fbfl_pkg::COUNT_MAX)) ?
                       int'(fbfl_pkg::COUNT_MAX) : MAX_BLOCKS;
  localparam logic [fbfl_pkg::COUNT_W-1:0] CAP_COUNT = fbfl_pkg::COUNT_W'(CAP);

  fbfl_pkg::state_t state_r, state_nxt;

  logic [LINK_W-1:0]             head_r;
  logic [fbfl_pkg::COUNT_W-1:0]  used_r;
  logic [fbfl_pkg::COUNT_W-1:0]  active_r;

  fbfl_pkg::op_t                 op_r;
  logic [fbfl_pkg::ADDR_W-1:0]   addr_r;
  logic [fbfl_pkg::ADDR_W-1:0]   blk_addr_r;
  logic                          ok_r;
  logic [fbfl_pkg::PROD_W-1:0]   prod_r;
  logic [fbfl_pkg::ADDR_W-1:0]   off_r;
  logic                          pre_r;
  logic [fbfl_pkg::PROD_W-1:0]   lim_r;
  logic [fbfl_pkg::COUNT_W-1:0]  swp_r;

  logic                          in_fire;
  logic                          head_empty;
  logic [fbfl_pkg::COUNT_W-1:0]  n_blocks;
  logic [fbfl_pkg::COUNT_W:0]    swp_inc;
  logic                          swp_last;
  logic                          chk_pass;
  logic                          free_hit;
  logic [fbfl_pkg::PROD_W-1:0]   head_ext;
  logic [fbfl_pkg::PROD_W-1:0]   active_ext;
  logic [fbfl_pkg::PROD_W-1:0]   stride_ext;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [LINK_W-1:0]             ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [LINK_W-1:0]             ram_rdata;
  logic [LINK_W-1:0]             link_clamp;

  logic                          div_start;
  fbfl_pkg::div_res_t            div_res;

  fbfl_link_ram #(
    .DEPTH     (MAX_BLOCKS),
    .ADDR_BITS (IDX_W),
    .DATA_BITS (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbfl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lim_r == '0 ? '0 : off_r[fbfl_pkg::PROD_W-1:0]),
    .divisor  (cfg.stride),
    .res      (div_res)
  );

  // Shared decode of the current request and registers.
  assign in_fire    = in_valid && in_ready;
  assign head_empty = (head_r == NULL_LINK);
  assign n_blocks   = (cfg.num_blocks > CAP_COUNT) ? CAP_COUNT : cfg.num_blocks;
  assign swp_inc    = {1'b0, swp_r} + 1'b1;
  assign swp_last   = (swp_inc >= {1'b0, active_r});
  assign head_ext   = fbfl_pkg::PROD_W'(fbfl_pkg::COUNT_W'(head_r));
  assign active_ext = fbfl_pkg::PROD_W'(active_r);
  assign stride_ext = fbfl_pkg::PROD_W'(cfg.stride);
  assign link_clamp = (ram_rdata > NULL_LINK) ? NULL_LINK : ram_rdata;
  assign chk_pass   = pre_r && (cfg.stride != '0) &&
                      (off_r < fbfl_pkg::ADDR_W'(lim_r));
  assign free_hit   = div_res.done && div_res.exact && (op_r == fbfl_pkg::OP_FREE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbfl_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            fbfl_pkg::OP_ALLOC:
              state_nxt = head_empty ? fbfl_pkg::S_RESP : fbfl_pkg::S_ALLOC_RD;
            fbfl_pkg::OP_FREE,
            fbfl_pkg::OP_CHECK:
              state_nxt = fbfl_pkg::S_CHK_PREP;
            fbfl_pkg::OP_REBUILD:
              state_nxt = (n_blocks == '0) ? fbfl_pkg::S_RESP : fbfl_pkg::S_REBUILD;
          endcase
        end
      end
      fbfl_pkg::S_ALLOC_RD: state_nxt = fbfl_pkg::S_RESP;
      fbfl_pkg::S_CHK_PREP: state_nxt = fbfl_pkg::S_CHK_TEST;
      fbfl_pkg::S_CHK_TEST: state_nxt = chk_pass ? fbfl_pkg::S_DIV : fbfl_pkg::S_RESP;
      fbfl_pkg::S_DIV:      state_nxt = div_res.done ? fbfl_pkg::S_RESP : fbfl_pkg::S_DIV;
      fbfl_pkg::S_REBUILD:  state_nxt = swp_last ? fbfl_pkg::S_RESP : fbfl_pkg::S_REBUILD;
      fbfl_pkg::S_RESP:     state_nxt = res_take ? fbfl_pkg::S_IDLE : fbfl_pkg::S_RESP;
      default:              state_nxt = fbfl_pkg::S_IDLE;
    endcase
  end

  // State outputs: handshake, memory ports and divider start.
  always_comb begin
    in_ready  = (state_r == fbfl_pkg::S_IDLE);
    res_valid = (state_r == fbfl_pkg::S_RESP);
    ram_re    = (state_r == fbfl_pkg::S_IDLE) && in_fire && (in_op == fbfl_pkg::OP_ALLOC);
    ram_raddr = IDX_W'(head_r);
    div_start = (state_r == fbfl_pkg::S_CHK_TEST) && chk_pass;
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(swp_r);
    ram_wdata = swp_last ? NULL_LINK : LINK_W'(swp_inc);
    unique case (state_r)
      fbfl_pkg::S_REBUILD: begin
        ram_we = 1'b1;
      end
      fbfl_pkg::S_DIV: begin
        ram_we    = free_hit;
        ram_waddr = IDX_W'(div_res.quotient);
        ram_wdata = head_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // State register, list head and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fbfl_pkg::S_IDLE;
      head_r   <= NULL_LINK;
      used_r   <= '0;
      active_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        fbfl_pkg::S_IDLE: begin
          if (in_fire && (in_op == fbfl_pkg::OP_REBUILD)) begin
            active_r <= n_blocks;
            used_r   <= '0;
            head_r   <= (n_blocks == '0) ? NULL_LINK : '0;
          end
        end
        fbfl_pkg::S_ALLOC_RD: begin
          head_r <= link_clamp;
          if (used_r != fbfl_pkg::COUNT_MAX) begin
            used_r <= used_r + 1'b1;
          end
        end
        fbfl_pkg::S_DIV: begin
          if (free_hit) begin
            head_r <= LINK_W'(div_res.quotient);
            if (used_r != '0) begin
              used_r <= used_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request payload and working values.
  always_ff @(posedge clk) begin
    unique case (state_r)
      fbfl_pkg::S_IDLE: begin
        if (in_fire) begin
          op_r       <= in_op;
          addr_r     <= in_addr;
          blk_addr_r <= '0;
          ok_r       <= (in_op == fbfl_pkg::OP_REBUILD);
          prod_r     <= head_ext * stride_ext;
          swp_r      <= '0;
        end
      end
      fbfl_pkg::S_ALLOC_RD: begin
        blk_addr_r <= cfg.base_address + fbfl_pkg::ADDR_W'(prod_r);
        ok_r       <= 1'b1;
      end
      fbfl_pkg::S_CHK_PREP: begin
        off_r <= addr_r - cfg.base_address;
        pre_r <= (addr_r != '0) && (addr_r >= cfg.base_address);
        lim_r <= active_ext * stride_ext;
      end
      fbfl_pkg::S_DIV: begin
        if (div_res.done) begin
          ok_r <= div_res.exact;
        end
      end
      fbfl_pkg::S_REBUILD: begin
        swp_r <= swp_inc[fbfl_pkg::COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Result fields from the final state of this request.
  always_comb begin
    res.block_address   = blk_addr_r;
    res.ok              = ok_r;
    res.used_count      = used_r;
    res.available_count = (active_r > used_r) ? (active_r - used_r) : '0;
    res.is_empty        = (used_r == '0);
    res.is_full         = (used_r == active_r);
  end

  // The divider reports completion only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == fbfl_pkg::S_DIV))
    else $error("divider finished outside the divide state");

  // The rebuild sweep never writes past the active pool.
  a_sweep_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbfl_pkg::S_REBUILD) |-> (swp_r < active_r))
    else $error("rebuild sweep beyond active block count");

  // The list head is null or names a block of the active pool.
  a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NULL_LINK) || (fbfl_pkg::COUNT_W'(head_r) < active_r))
    else $error("list head outside the active pool");

  // An accepted request always moves the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != fbfl_pkg::S_IDLE))
    else $error("accepted request did not start");

endmodule

/* tb/fbfl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_checker
// Watches the request, result and register channels of the block allocator,
// keeps its own copy of the free list and counters, works out the result of
// every accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module fbfl_checker
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [ADDR_W-1:0]      in_tdata,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     results_seen,
  output int                     mismatch_count
);

  // The end-of-list marker is one past the last block index.
  localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(MAX_BLOCKS);
  localparam int PRINT_CAP = 100;

  // Register copies as the block sees them.
  logic [ADDR_W-1:0]   base_addr;
  logic [STRIDE_W-1:0] stride;
  logic [COUNT_W-1:0]  blocks_cfg;

  // Free list and counters.
  logic [COUNT_W-1:0]  link_mem [MAX_BLOCKS];
  logic [COUNT_W-1:0]  free_head;
  logic [COUNT_W-1:0]  used_blocks;
  logic [COUNT_W-1:0]  pool_blocks;

  res_t                expected_results [$];
  res_t                predicted;
  int                  n_seen;
  int                  n_bad;

  // An address belongs to the pool when it is nonzero, at or above the base,
  // inside the pool span and a whole number of strides from the base.
  function automatic bit locate_block(input logic [ADDR_W-1:0] addr,
                                      output logic [COUNT_W-1:0] idx);
    logic [ADDR_W-1:0] offset;
    logic [63:0]       span;
    idx = '0;
    if (addr == '0 || addr < base_addr || stride == '0) return 1'b0;
    offset = addr - base_addr;
    span   = 64'(pool_blocks) * 64'(stride);
    if (64'(offset) >= span || (offset % stride) != 0) return 1'b0;
    idx = COUNT_W'(offset / stride);
    return 1'b1;
  endfunction

  // Applies one request to the free list and builds the result it must give.
  task automatic predict_pool_op(input op_t op, input logic [ADDR_W-1:0] addr,
                                 output res_t result);
    logic [COUNT_W-1:0] idx;
    logic [COUNT_W-1:0] nxt;
    logic [COUNT_W-1:0] n;
    int                 i;
    result = '0;
    case (op)
      OP_ALLOC: begin
        if (free_head < NULL_LINK) begin
          idx = free_head;
          result.block_address = base_addr + 32'(idx) * 32'(stride);
          nxt = link_mem[idx];
          free_head = (nxt > NULL_LINK) ? NULL_LINK : nxt;
          if (used_blocks < COUNT_MAX) used_blocks = used_blocks + 1'b1;
          result.ok = 1'b1;
        end
      end
      OP_FREE: begin
        // A repeated free is pushed again; the count stops at zero.
        if (locate_block(addr, idx)) begin
          link_mem[idx] = free_head;
          free_head = idx;
          if (used_blocks != '0) used_blocks = used_blocks - 1'b1;
          result.ok = 1'b1;
        end
      end
      OP_REBUILD: begin
        n = (blocks_cfg > NULL_LINK) ? NULL_LINK : blocks_cfg;
        pool_blocks = n;
        used_blocks = '0;
        for (i = 0; i < n; i++)
          link_mem[i] = (i + 1 < n) ? COUNT_W'(i + 1) : NULL_LINK;
        free_head = (n == '0) ? NULL_LINK : '0;
        result.ok = 1'b1;
      end
      OP_CHECK: begin
        result.ok = locate_block(addr, idx);
      end
    endcase
    result.used_count      = used_blocks;
    result.available_count = (pool_blocks > used_blocks) ? pool_blocks - used_blocks : '0;
    result.is_empty        = (used_blocks == '0);
    result.is_full         = (used_blocks == pool_blocks);
  endtask

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] seen);
    if (n_bad < PRINT_CAP)
      $display("%0t: %s mismatch on result %0d, expected 0x%0h, got 0x%0h",
               $time, field, n_seen, want, seen);
    n_bad++;
  endtask

  task automatic compare_result(input res_t want, input logic [OUT_TDATA_W-1:0] raw);
    res_t got;
    got = res_t'(raw[OUT_BITS-1:0]);
    if (got.block_address !== want.block_address)
      report_mismatch("block_address", want.block_address, got.block_address);
    if (got.ok !== want.ok)
      report_mismatch("ok", want.ok, got.ok);
    if (got.used_count !== want.used_count)
      report_mismatch("used_count", want.used_count, got.used_count);
    if (got.available_count !== want.available_count)
      report_mismatch("available_count", want.available_count, got.available_count);
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", want.is_empty, got.is_empty);
    if (got.is_full !== want.is_full)
      report_mismatch("is_full", want.is_full, got.is_full);
    if (raw[OUT_TDATA_W-1:OUT_BITS] !== '0)
      report_mismatch("padding", '0, 32'(raw[OUT_TDATA_W-1:OUT_BITS]));
  endtask

  // Register writes first, then new requests, then finished results.
  always @(posedge clk) begin
    if (!rst_n) begin
      base_addr   = '0;
      stride      = STRIDE_W'(4);
      blocks_cfg  = '0;
      free_head   = NULL_LINK;
      used_blocks = '0;
      pool_blocks = '0;
      expected_results.delete();
      n_seen = 0;
      n_bad  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:   base_addr  = cfg_data;
          CFG_STRIDE: stride     = cfg_data[STRIDE_W-1:0];
          CFG_BLOCKS: blocks_cfg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_pool_op(op_t'(in_tuser), in_tdata, predicted);
        expected_results.push_back(predicted);
      end
      if (out_tvalid && out_tready) begin
        n_seen++;
        if (expected_results.size() == 0)
          report_mismatch("unrequested result", '0, out_tdata[ADDR_W-1:0]);
        else
          compare_result(expected_results.pop_front(), out_tdata);
      end
    end
    results_seen   <= n_seen;
    mismatch_count <= n_bad;
  end

endmodule

/* tb/fixed_block_free_list_allocator_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top_test
// Drives alloc, free, rebuild and check requests into the block allocator
// under a series of base, stride and block count settings, with random gaps
// on the request side and random stalls on the result side. A checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top_test;
  import fbfl_pkg::*;

  localparam int POOL_SIZE    = 1024;
  localparam int RANDOM_ITEMS = 930;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [ADDR_W-1:0]      in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int results_seen;
  int mismatch_count;

  // Gap and stall rates in percent, and the remaining stall of a burst.
  int tx_pct  = 20;
  int rx_pct  = 5;
  int rx_hold = 0;
  int cycle_count = 0;

  // What the stimulus knows of the pool, for choosing addresses.
  logic [ADDR_W-1:0]   pool_base      = '0;
  logic [STRIDE_W-1:0] pool_stride    = STRIDE_W'(4);
  logic [COUNT_W-1:0]  blocks_written = '0;
  int                  live_blocks    = 0;

  int requests_sent = 0;
  int settings_used = 1;
  int op_tally [4]  = '{default: 0};

  always #5 clk = ~clk;

  fixed_block_free_list_allocator_top #(.MAX_BLOCKS(POOL_SIZE)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fbfl_checker #(.MAX_BLOCKS(POOL_SIZE)) pool_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .results_seen   (results_seen),
    .mismatch_count (mismatch_count)
  );

  // Result side: out_tready drops in random bursts of stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      rx_hold    <= 0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
      out_tready <= 1'b0;
      rx_hold    <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d results back.",
               cycle_count, results_seen, requests_sent);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] block_at(input int idx);
    return pool_base + ADDR_W'(idx) * ADDR_W'(pool_stride);
  endfunction

  // Mostly real block starts; the rest are misaligned, out of range or odd.
  function automatic logic [ADDR_W-1:0] pick_address(input int member_pct);
    int pick;
    if (live_blocks > 0 && $urandom_range(0, 99) < member_pct)
      return block_at($urandom_range(0, live_blocks - 1));
    pick = $urandom_range(0, 5);
    case (pick)
      0:       return $urandom;
      1:       return block_at($urandom_range(0, live_blocks)) + $urandom_range(1, 3);
      2:       return pool_base - pool_stride;
      3:       return block_at(live_blocks);
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  // Sends one request, with an optional gap in front of it.
  task automatic issue(input op_t op, input logic [ADDR_W-1:0] addr);
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    op_tally[op]++;
    if (op == OP_REBUILD)
      live_blocks = (blocks_written > POOL_SIZE) ? POOL_SIZE : int'(blocks_written);
  endtask

  // Holds off new requests until every result is back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE:   pool_base      = data;
      CFG_STRIDE: pool_stride    = data[STRIDE_W-1:0];
      CFG_BLOCKS: blocks_written = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] base_word,
                           input logic [CFG_DATA_W-1:0] stride_word,
                           input logic [CFG_DATA_W-1:0] blocks_word,
                           input bit spare);
    wait_idle();
    write_reg(CFG_BASE, base_word);
    write_reg(CFG_STRIDE, stride_word);
    write_reg(CFG_BLOCKS, blocks_word);
    if (spare) write_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int random_done;
    int len;
    int pick;
    bit quiet;
    logic [ADDR_W-1:0]   base_sel;
    logic [STRIDE_W-1:0] stride_sel;
    logic [COUNT_W-1:0]  blocks_sel;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: empty list and an empty pool.
    issue(OP_ALLOC, $urandom);
    issue(OP_FREE, 32'h4);
    issue(OP_REBUILD, $urandom);

    // Three blocks from address zero: exhaust, double free, count floor.
    configure(32'h0, 32'h4, 32'h3, 1'b0);
    issue(OP_REBUILD, $urandom);
    repeat (4) issue(OP_ALLOC, $urandom);
    issue(OP_FREE, 32'h0);
    issue(OP_FREE, 32'h8);
    issue(OP_FREE, 32'h8);
    repeat (2) issue(OP_ALLOC, $urandom);
    issue(OP_CHECK, 32'h4);
    issue(OP_CHECK, 32'h6);
    issue(OP_CHECK, 32'hC);
    issue(OP_REBUILD, $urandom);
    issue(OP_FREE, 32'h4);

    // Base near the top so block addresses wrap; also the undecoded index.
    configure(32'hFFFF_FFF0, 32'h8, 32'h4, 1'b1);
    issue(OP_REBUILD, $urandom);
    repeat (3) issue(OP_ALLOC, $urandom);
    issue(OP_CHECK, 32'hFFFF_FFE8);

    // Zero stride with an oversized block count and junk in the upper bits.
    configure(32'h0000_1000, 32'hA5A5_0000, 32'hFFFF_FFFF, 1'b0);
    issue(OP_REBUILD, $urandom);
    repeat (2) issue(OP_ALLOC, $urandom);
    issue(OP_CHECK, 32'h0000_1000);

    // Random phases: new settings, usually a rebuild, then a mix of requests.
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      quiet = (random_done >= RANDOM_ITEMS - QUIET_TAIL);

      pick = $urandom_range(0, 99);
      if (pick < 5)       blocks_sel = '0;
      else if (pick < 9)  blocks_sel = COUNT_W'(POOL_SIZE);
      else if (pick < 11) blocks_sel = '1;
      else if (pick < 13) blocks_sel = $urandom_range(POOL_SIZE + 1, 2046);
      else if (pick < 20) blocks_sel = $urandom_range(17, 64);
      else                blocks_sel = $urandom_range(1, 16);

      pick = $urandom_range(0, 99);
      if (pick < 5)       stride_sel = '0;
      else if (pick < 10) stride_sel = $urandom_range(1, 65535);
      else if (pick < 15) stride_sel = 16'd65532;
      else if (pick < 18) stride_sel = '1;
      else if (pick < 22) stride_sel = 16'd4;
      else                stride_sel = 16'($urandom_range(1, 16383) * 4);

      pick = $urandom_range(0, 99);
      if (pick < 10)      base_sel = '0;
      else if (pick < 20) base_sel = 32'hFFFF_FFFF - $urandom_range(0, 4096);
      else                base_sel = $urandom;

      configure(base_sel,
                {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0, stride_sel},
                {($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'h0, blocks_sel},
                1'b0);

      if (quiet) begin
        tx_pct = 0;
        rx_pct <= 0;
      end else begin
        pick = $urandom_range(0, 2);
        tx_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
        rx_pct <= (pick == 0) ? 0 : (pick == 1) ? 5 : 20;
      end

      // Now and then the old list is kept under the new settings.
      if ($urandom_range(0, 9) != 0) begin
        issue(OP_REBUILD, $urandom);
        random_done++;
      end

      len = $urandom_range(20, 70);
      if (!quiet && len > RANDOM_ITEMS - QUIET_TAIL - random_done)
        len = RANDOM_ITEMS - QUIET_TAIL - random_done;
      while (len > 0 && random_done < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      issue(OP_ALLOC, $urandom);
        else if (pick < 72) issue(OP_FREE, pick_address(70));
        else if (pick < 96) issue(OP_CHECK, pick_address(60));
        else                issue(OP_REBUILD, $urandom);
        random_done++;
        len--;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d alloc, %0d free, %0d rebuild, %0d check) over %0d settings.",
             requests_sent, op_tally[OP_ALLOC], op_tally[OP_FREE],
             op_tally[OP_REBUILD], op_tally[OP_CHECK], settings_used);
    $display("%0d results compared with the predicted pool state, %0d mismatches.",
             results_seen, mismatch_count);
    if (mismatch_count == 0 && results_seen == requests_sent) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
